// ===== sv/sdpm_pkg.sv =====
// Package for the stick deadband percentage map.
// Holds configuration register indexes, reset values and scaling constants.
// No dependencies.
package sdpm_pkg;

    localparam int ADC_BITS_DEF = 12;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_CH0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_CH1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MAX  = 3'd4;

    localparam int RST_DEADBAND   = 130;
    localparam int RST_CENTER     = 2048;
    localparam int RST_CENTER_MIN = 300;
    localparam int RST_CENTER_MAX = 3795;

    localparam int PCT_W    = 8;
    localparam int QUOT_W   = 7;
    localparam logic [QUOT_W-1:0] PCT_FULL = 7'd100;

endpackage

// ===== sv/stick_deadband_percent_map.sv =====
// Top level of the stick deadband percentage map.
// Depends on sdpm_pkg; a single pipelined datapath with a bit-per-stage divider.

// Each transaction carries one converter sample and a channel number and yields one
// transaction with a signed percentage and a fault flag. The block is fully pipelined:
// it accepts a new transaction in every cycle while the output side does not stall, and
// each result passes through eleven register stages: three front stages, seven
// restoring-divider stages that each settle one quotient bit, and the output register.
// When the output stalls with a result waiting, the whole pipeline freezes and o_stall is
// raised toward the input side, so nothing is lost or repeated. The five configuration
// registers (deadband, left and right center, center window minimum and maximum) are
// written through i_cfg_we/i_cfg_idx/i_cfg_data and must only change while no
// transaction is in flight; writes to an index past the last register are ignored.
module stick_deadband_percent_map #(
    parameter int ADC_BITS = sdpm_pkg::ADC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [sdpm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADC_BITS-1:0]           i_cfg_data,
    // Input channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_channel,
    input  logic [ADC_BITS-1:0]           i_raw,
    // Output channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [sdpm_pkg::PCT_W-1:0] o_percent,
    output logic                          o_fault
);
    import sdpm_pkg::*;

    // The scaled excess is below 128 * 2^ADC_BITS, so seven extra bits hold it.
    localparam int NUM_W  = ADC_BITS + QUOT_W;
    localparam logic [ADC_BITS-1:0] FULL = {ADC_BITS{1'b1}};

    typedef struct packed {
        logic                valid;
        logic                active;
        logic                neg;
        logic                fault;
        logic                sat;
        logic [ADC_BITS-1:0] span;
        logic [NUM_W-1:0]    rem;
        logic [QUOT_W-1:0]   quot;
    } t_dv;

    // Configuration registers.
    logic [ADC_BITS-1:0] r_deadband, r_center_ch0, r_center_ch1;
    logic [ADC_BITS-1:0] r_center_min, r_center_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband     <= ADC_BITS'(RST_DEADBAND);
            r_center_ch0   <= ADC_BITS'(RST_CENTER);
            r_center_ch1   <= ADC_BITS'(RST_CENTER);
            r_center_min   <= ADC_BITS'(RST_CENTER_MIN);
            r_center_max   <= ADC_BITS'(RST_CENTER_MAX);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEADBAND:    r_deadband     <= i_cfg_data;
                CFG_CENTER_CH0:  r_center_ch0   <= i_cfg_data;
                CFG_CENTER_CH1:  r_center_ch1   <= i_cfg_data;
                CFG_CENTER_MIN:  r_center_min   <= i_cfg_data;
                CFG_CENTER_MAX:  r_center_max   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Every stage moves together; the pipeline freezes only while a finished
    // result sits in the output register and the consumer stalls.
    logic w_adv;
    assign w_adv   = !o_valid || !i_stall;
    assign o_stall = !w_adv;

    // Stage 1: center selection, signed difference and the calibration check.
    logic                       r1_valid, n1_valid;
    logic signed [ADC_BITS:0]   r1_delta, n1_delta;
    logic [ADC_BITS-1:0]        r1_center, n1_center;
    logic                       r1_fault, n1_fault;

    always_comb begin
        n1_valid  = i_valid;
        n1_center = i_channel ? r_center_ch1 : r_center_ch0;
        n1_delta  = $signed({1'b0, i_raw}) - $signed({1'b0, n1_center});
        n1_fault  = (r_center_ch0 < r_center_min) || (r_center_ch0 > r_center_max) ||
                    (r_center_ch1 < r_center_min) || (r_center_ch1 > r_center_max);
    end

    // Stage 2: magnitude against the deadband, excess and the span of the side.
    logic                       r2_valid, n2_valid;
    logic                       r2_active, n2_active;
    logic                       r2_neg, n2_neg;
    logic                       r2_fault, n2_fault;
    logic [ADC_BITS-1:0]        r2_excess, n2_excess;
    logic [ADC_BITS-1:0]        r2_span, n2_span;
    logic [ADC_BITS:0]          w2_mag;
    logic signed [ADC_BITS+1:0] w2_side;

    always_comb begin
        n2_valid  = r1_valid;
        n2_fault  = r1_fault;
        n2_neg    = r1_delta < 0;
        w2_mag    = n2_neg ? (ADC_BITS+1)'(-r1_delta) : (ADC_BITS+1)'(r1_delta);
        n2_active = !r1_fault && (w2_mag > {1'b0, r_deadband});
        n2_excess = w2_mag[ADC_BITS-1:0] - r_deadband;
        if (n2_neg) begin
            w2_side = $signed({2'b00, r1_center}) - $signed({2'b00, r_deadband});
        end else begin
            w2_side = $signed({2'b00, FULL}) - $signed({2'b00, r1_center})
                      - $signed({2'b00, r_deadband});
        end
        // A span that is not positive counts as one, which saturates the result.
        n2_span = (w2_side <= 0) ? ADC_BITS'(1) : w2_side[ADC_BITS-1:0];
    end

    // Stage 3: excess times 100 as shift-adds, and the early saturation test
    // for a quotient of 128 or more.
    t_dv              r_dv [0:QUOT_W];
    t_dv              n_dv [0:QUOT_W];
    logic [NUM_W-1:0] w3_num;

    always_comb begin
        w3_num = NUM_W'({r2_excess, 6'b0}) + NUM_W'({r2_excess, 5'b0})
                 + NUM_W'({r2_excess, 2'b0});
        n_dv[0].valid  = r2_valid;
        n_dv[0].active = r2_active;
        n_dv[0].neg    = r2_neg;
        n_dv[0].fault  = r2_fault;
        n_dv[0].span   = r2_span;
        n_dv[0].sat    = w3_num >= {r2_span, {QUOT_W{1'b0}}};
        n_dv[0].rem    = w3_num;
        n_dv[0].quot   = '0;
    end

    // Restoring divider: stage j settles quotient bit QUOT_W-1-j.
    for (genvar j = 0; j < QUOT_W; j++) begin : g_div
        localparam int BIT = QUOT_W - 1 - j;
        logic [NUM_W-1:0] w_dsr;
        always_comb begin
            w_dsr        = NUM_W'(r_dv[j].span) << BIT;
            n_dv[j+1]    = r_dv[j];
            if (r_dv[j].rem >= w_dsr) begin
                n_dv[j+1].rem       = r_dv[j].rem - w_dsr;
                n_dv[j+1].quot[BIT] = 1'b1;
            end
        end
    end

    // Output stage: clip to 100, apply the sign of the deflection, and give zero inside the deadband or on a fault.
    logic                     r_out_valid;
    logic signed [PCT_W-1:0]  r_percent, n_percent;
    logic                     r_fault_q;
    logic [QUOT_W-1:0]        w_mag_pct;

    always_comb begin
        w_mag_pct = (r_dv[QUOT_W].sat || r_dv[QUOT_W].quot > PCT_FULL) ?
                    PCT_FULL : r_dv[QUOT_W].quot;
        if (!r_dv[QUOT_W].active) begin
            n_percent = '0;
        end else if (r_dv[QUOT_W].neg) begin
            n_percent = -$signed({1'b0, w_mag_pct});
        end else begin
            n_percent = $signed({1'b0, w_mag_pct});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= QUOT_W; k++) begin
                r_dv[k].valid <= 1'b0;
            end
        end else if (w_adv) begin
            r1_valid    <= n1_valid;
            r1_delta    <= n1_delta;
            r1_center   <= n1_center;
            r1_fault    <= n1_fault;
            r2_valid    <= n2_valid;
            r2_active   <= n2_active;
            r2_neg      <= n2_neg;
            r2_fault    <= n2_fault;
            r2_excess   <= n2_excess;
            r2_span     <= n2_span;
            for (int k = 0; k <= QUOT_W; k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_out_valid <= r_dv[QUOT_W].valid;
            r_percent   <= n_percent;
            r_fault_q   <= r_dv[QUOT_W].fault;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_percent = r_percent;
    assign o_fault   = r_fault_q;

endmodule

// ===== sv/sdpm_checker.sv =====
// Port-level checker for the stick deadband percentage map, with its bind.
// Depends on sdpm_pkg and on the ports of stick_deadband_percent_map.
module sdpm_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_stall,
    input logic                                  o_valid,
    input logic                                  i_stall,
    input logic signed [sdpm_pkg::PCT_W-1:0]     o_percent,
    input logic                                  o_fault
);
    import sdpm_pkg::*;

    // A faulted calibration never shows a deflection.
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fault |-> o_percent == '0)
        else $error("percent not zero while fault is raised");

    // The percentage stays within plus and minus full scale.
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_percent <= $signed(PCT_W'(PCT_FULL))) &&
                    (o_percent >= -$signed(PCT_W'(PCT_FULL))))
        else $error("percent out of range");

    // Back-pressure reaches the input only while a result is held at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_percent) && $stable(o_fault))
        else $error("stalled result changed");

endmodule

bind stick_deadband_percent_map sdpm_checker u_sdpm_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the stick deadband percentage map.
// Depends on sdpm_pkg and stick_deadband_percent_map; it drives random and directed samples
// and compares every result with a percentage predicted from the register settings.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sdpm_pkg::*;

    localparam int ADC_BITS   = ADC_BITS_DEF;
    localparam int FULL_SCALE = (1 << ADC_BITS) - 1;
    localparam int PCT_LIMIT  = 100;

    // The receiver holds off this long once, so the pipeline fills and stalls its input.
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_PHASES   = 15;
    localparam int PHASE_SAMPLES   = 100;
    localparam int PRESSURE_PHASE  = 2;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct {
        logic signed [PCT_W-1:0] pct;
        logic                    fault;
    } t_deflection;

    // Keeps a private copy of the five registers and a queue of the deflections expected
    // from the samples the block has accepted, oldest first.
    class deflection_board;
        logic [ADC_BITS-1:0] deadband;
        logic [ADC_BITS-1:0] center_ch0;
        logic [ADC_BITS-1:0] center_ch1;
        logic [ADC_BITS-1:0] center_min;
        logic [ADC_BITS-1:0] center_max;
        t_deflection         expected_q[$];
        int                  errors;

        function new();
            deadband     = ADC_BITS'(RST_DEADBAND);
            center_ch0   = ADC_BITS'(RST_CENTER);
            center_ch1   = ADC_BITS'(RST_CENTER);
            center_min   = ADC_BITS'(RST_CENTER_MIN);
            center_max   = ADC_BITS'(RST_CENTER_MAX);
            errors       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADC_BITS-1:0] data);
            case (idx)
                CFG_DEADBAND:    deadband     = data;
                CFG_CENTER_CH0:  center_ch0   = data;
                CFG_CENTER_CH1:  center_ch1   = data;
                CFG_CENTER_MIN:  center_min   = data;
                CFG_CENTER_MAX:  center_max   = data;
                default: ;
            endcase
        endfunction

        function bit center_bad(logic [ADC_BITS-1:0] c);
            return (c < center_min) || (c > center_max);
        endfunction

        // Scales the excess beyond the deadband to a percentage of the span on its side.
        function logic signed [PCT_W-1:0] scale_side(int excess, int span);
            int s;
            int q;
            s = (span < 1) ? 1 : span;
            q = (excess * PCT_LIMIT) / s;
            if (q > PCT_LIMIT) q = PCT_LIMIT;
            if (q < -PCT_LIMIT) q = -PCT_LIMIT;
            return q[PCT_W-1:0];
        endfunction

        function t_deflection map_deflection(bit ch, logic [ADC_BITS-1:0] raw);
            t_deflection d;
            int          sample;
            int          center;
            int          db;
            int          delta;
            int          mag;
            sample  = raw;
            center  = ch ? center_ch1 : center_ch0;
            db      = deadband;
            delta   = sample - center;
            mag     = (delta < 0) ? -delta : delta;
            d.fault = center_bad(center_ch0) || center_bad(center_ch1);
            d.pct   = '0;
            if (!d.fault && mag > db) begin
                if (delta > 0) begin
                    d.pct = scale_side(delta - db, FULL_SCALE - center - db);
                end else begin
                    d.pct = scale_side(delta + db, center - db);
                end
            end
            return d;
        endfunction

        function void note_sample(bit ch, logic [ADC_BITS-1:0] raw);
            expected_q.push_back(map_deflection(ch, raw));
        endfunction

        function void check_deflection(logic signed [PCT_W-1:0] pct, logic fault);
            t_deflection want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, percent %0d fault %0b",
                         $time, pct, fault);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (pct !== want.pct) begin
                $display("%0t: percent mismatch, expected %0d, actual %0d",
                         $time, want.pct, pct);
                errors++;
            end
            if (fault !== want.fault) begin
                $display("%0t: fault mismatch, expected %0b, actual %0b",
                         $time, want.fault, fault);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n    = 1'b0;
    logic                       i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx  = '0;
    logic [ADC_BITS-1:0]        i_cfg_data = '0;
    logic                       i_valid    = 1'b0;
    logic                       o_stall;
    logic                       i_channel  = 1'b0;
    logic [ADC_BITS-1:0]        i_raw      = '0;
    logic                       o_valid;
    logic                       i_stall    = 1'b0;
    logic signed [PCT_W-1:0]    o_percent;
    logic                       o_fault;

    // Shared between the stimulus and the receiver: a request for the long hold-off,
    // and whether the sender leaves gaps between transactions in the current phase.
    bit hold_off_req = 1'b0;
    bit sender_gaps  = 1'b1;

    deflection_board board = new();

    stick_deadband_percent_map #(
        .ADC_BITS(ADC_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_channel  (i_channel),
        .i_raw      (i_raw),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_percent  (o_percent),
        .o_fault    (o_fault)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Both handshakes are sampled right at the rising edge, before any register of the
    // block or any driver of this bench has applied its update for that edge. A sample
    // accepted at an edge cannot leave the pipeline at the same edge, so the order of the
    // two calls does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            board.note_sample(i_channel, i_raw);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_deflection(o_percent, o_fault);
        end
    end

    // Receiver: alternates free-running stretches with short stalls and an occasional long
    // one. When the stimulus asks for it, it holds off once for the long hold-off so
    // the output register backs up and the block raises o_stall toward the sender.
    initial begin
        int r;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    i_stall <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge i_clk);
                end else if (r < 93) begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(8, 30)) @(posedge i_clk);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one sample and returns at the edge where it was taken, or after the idle gap
    // that may follow. Valid stays high through a stall with the payload unchanged; during
    // the gap the payload wanders since nobody looks at it.
    task automatic send_sample(bit ch, logic [ADC_BITS-1:0] raw);
        int gap;
        i_valid   <= 1'b1;
        i_channel <= ch;
        i_raw     <= raw;
        do @(posedge i_clk); while (o_stall);
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid   <= 1'b0;
            i_channel <= 1'($urandom_range(0, 1));
            i_raw     <= ADC_BITS'($urandom_range(0, FULL_SCALE));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Every sample yields exactly one result, so an empty expectation queue means the
    // pipeline holds nothing. The first edge is always waited for, so a sample taken at
    // the edge where the caller returned has been noted before the queue is looked at.
    task automatic wait_idle();
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Leaves i_cfg_we high; the caller lowers it after the last write of a batch so the
    // enable is never dropped and raised within one time step.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADC_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    // Rewrites all five registers once the block has drained. Every batch ends with a
    // write to an index past the last register, which the block has to ignore.
    task automatic apply_settings(int db, int lc, int rc, int lo, int hi);
        i_valid <= 1'b0;
        wait_idle();
        write_reg(CFG_DEADBAND, db[ADC_BITS-1:0]);
        write_reg(CFG_CENTER_CH0, lc[ADC_BITS-1:0]);
        write_reg(CFG_CENTER_CH1, rc[ADC_BITS-1:0]);
        write_reg(CFG_CENTER_MIN, lo[ADC_BITS-1:0]);
        write_reg(CFG_CENTER_MAX, hi[ADC_BITS-1:0]);
        write_reg(CFG_IDX_W'($urandom_range(CFG_CENTER_MAX + 1, (1 << CFG_IDX_W) - 1)),
                  ADC_BITS'($urandom_range(0, FULL_SCALE)));
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_center(int lo, int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80 && lo <= hi) return $urandom_range(lo, hi);
        if (r < 90) return $urandom_range(0, 1) ? FULL_SCALE : 0;
        return $urandom_range(0, FULL_SCALE);
    endfunction

    // Mostly a well-formed calibration (both centers inside a sensible window) so the
    // scaling path is exercised; the rest covers extremes, empty windows and faults.
    task automatic random_settings();
        int r;
        int db;
        int lo;
        int hi;
        r = $urandom_range(0, 99);
        if (r < 10) db = 0;
        else if (r < 15) db = FULL_SCALE;
        else if (r < 75) db = $urandom_range(0, 300);
        else db = $urandom_range(0, FULL_SCALE);
        r = $urandom_range(0, 99);
        if (r < 75) begin
            lo = $urandom_range(0, 1000);
            hi = $urandom_range(3000, FULL_SCALE);
        end else if (r < 83) begin
            lo = 0;
            hi = FULL_SCALE;
        end else if (r < 90) begin
            hi = $urandom_range(0, FULL_SCALE - 1);
            lo = $urandom_range(hi + 1, FULL_SCALE);
        end else begin
            lo = $urandom_range(0, FULL_SCALE);
            hi = $urandom_range(0, FULL_SCALE);
        end
        apply_settings(db, pick_center(lo, hi), pick_center(lo, hi), lo, hi);
    endtask

    // Samples cluster around the deadband edges of the selected center, where the rounding
    // and the zero region meet, and near the center and the rails, with plenty of full-range values.
    function automatic logic [ADC_BITS-1:0] pick_raw(bit ch);
        int r;
        int v;
        int center;
        int db;
        center = ch ? board.center_ch1 : board.center_ch0;
        db     = board.deadband;
        r      = $urandom_range(0, 99);
        if (r < 45) begin
            v = $urandom_range(0, FULL_SCALE);
        end else if (r < 80) begin
            v = db + $urandom_range(0, 4) - 2;
            v = $urandom_range(0, 1) ? center + v : center - v;
        end else if (r < 90) begin
            v = $urandom_range(0, 1) ? FULL_SCALE : 0;
        end else begin
            v = center + $urandom_range(0, 40) - 20;
        end
        if (v < 0) v = 0;
        if (v > FULL_SCALE) v = FULL_SCALE;
        return v[ADC_BITS-1:0];
    endfunction

    initial begin
        bit ch;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: both rails, dead center, and both sides of each deadband edge.
        send_sample(1'b0, 12'd0);
        send_sample(1'b1, ADC_BITS'(FULL_SCALE));
        send_sample(1'b0, ADC_BITS'(RST_CENTER));
        send_sample(1'b1, ADC_BITS'(RST_CENTER + RST_DEADBAND));
        send_sample(1'b0, ADC_BITS'(RST_CENTER + RST_DEADBAND + 1));
        send_sample(1'b1, ADC_BITS'(RST_CENTER - RST_DEADBAND));
        send_sample(1'b0, ADC_BITS'(RST_CENTER - RST_DEADBAND - 1));

        // Centers at the rails with no deadband: one side of each stick has zero span.
        apply_settings(0, 0, FULL_SCALE, 0, FULL_SCALE);
        send_sample(1'b0, 12'd0);
        send_sample(1'b0, 12'd1);
        send_sample(1'b0, ADC_BITS'(FULL_SCALE));
        send_sample(1'b1, ADC_BITS'(FULL_SCALE));
        send_sample(1'b1, 12'd0);

        // A deadband wider than the room to the near rail drives each stick's span on that side below one.
        apply_settings(150, 4000, 100, 0, FULL_SCALE);
        send_sample(1'b0, ADC_BITS'(FULL_SCALE));
        send_sample(1'b1, 12'd0);

        // A deadband that covers the whole range keeps every output at zero.
        apply_settings(FULL_SCALE, 1000, 3000, 0, FULL_SCALE);
        send_sample(1'b0, ADC_BITS'(FULL_SCALE));
        send_sample(1'b1, 12'd0);

        // Left center below the window, then right center above it: fault forces zero.
        apply_settings(RST_DEADBAND, 100, RST_CENTER, RST_CENTER_MIN, RST_CENTER_MAX);
        send_sample(1'b0, ADC_BITS'(FULL_SCALE));
        send_sample(1'b1, 12'd0);
        apply_settings(RST_DEADBAND, RST_CENTER, 4000, RST_CENTER_MIN, RST_CENTER_MAX);
        send_sample(1'b1, ADC_BITS'(FULL_SCALE));

        // A window whose minimum lies above its maximum rejects every center.
        apply_settings(0, RST_CENTER, RST_CENTER, FULL_SCALE, 0);
        send_sample(1'b0, ADC_BITS'(FULL_SCALE));
        send_sample(1'b1, 12'd0);

        // Random phases, each under fresh settings. One phase runs without sender gaps
        // while the receiver holds off, so the block is forced to back-pressure.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_settings();
            if (phase == PRESSURE_PHASE) begin
                sender_gaps  = 1'b0;
                hold_off_req = 1'b1;
            end else begin
                sender_gaps = ($urandom_range(0, 3) != 0);
            end
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                ch = 1'($urandom_range(0, 1));
                send_sample(ch, pick_raw(ch));
            end
        end

        i_valid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog: a correct run needs a small fraction of this time.
    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
